// ===== rtl/sida_pkg.sv =====
// Shared types and character constants for the signed integer to decimal text block.
// No dependencies; the front, back and top-level files refer to this package by scoped names.
package sida_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Classification of one accepted word, decided by the front part.
  typedef struct packed {
    logic neg;
    logic has_sign;
    logic term;
  } cls_t;

  // Status of the queue between the front and back parts.
  typedef struct packed {
    logic valid;
    cls_t cls;
  } fq_stat_t;

  // One result word.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [3:0] length;
  } chr_t;

endpackage

// ===== rtl/sida_front.sv =====
// Front part: input handshake, configuration register, sign classification and
// the two-entry queue that feeds the back part. Depends on sida_pkg.
module sida_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_add_terminator,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_show_plus,
  output sida_pkg::fq_stat_t     fq_stat,
  output logic [VALUE_WIDTH-1:0] fq_mag,
  input  logic                   fq_pop
);

  logic                   show_plus_r;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   wr_ptr_r, rd_ptr_r;
  sida_pkg::cls_t         cls_q [2];
  logic [VALUE_WIDTH-1:0] mag_q [2];
  logic                   push_ok, pop_ok;
  sida_pkg::cls_t         cls_in;
  logic [VALUE_WIDTH-1:0] mag_in;

  assign cfg_ready = 1'b1;
  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = fq_pop && (cnt_r != 2'd0);

  // The magnitude of the most negative word still fits as an unsigned value.
  always_comb begin
    cls_in.neg      = in_value[VALUE_WIDTH-1];
    cls_in.has_sign = in_value[VALUE_WIDTH-1] || show_plus_r;
    cls_in.term     = in_add_terminator;
    mag_in = in_value[VALUE_WIDTH-1] ?
             (~in_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_plus_r <= 1'b0;
      cnt_r       <= 2'd0;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        show_plus_r <= cfg_show_plus;
      end
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      cls_q[wr_ptr_r] <= cls_in;
      mag_q[wr_ptr_r] <= mag_in;
    end
  end

  assign fq_stat.valid = (cnt_r != 2'd0);
  assign fq_stat.cls   = cls_q[rd_ptr_r];
  assign fq_mag        = mag_q[rd_ptr_r];

endmodule

// ===== rtl/sida_back.sv =====
// Back part: bit-serial binary to BCD conversion, leading zero skip, character
// emission and the two-entry result queue. Depends on sida_pkg.
module sida_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sida_pkg::fq_stat_t     fq_stat,
  input  logic [VALUE_WIDTH-1:0] fq_mag,
  output logic                   fq_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [7:0]             out_character,
  output logic                   out_last,
  output logic [3:0]             out_length
);

  // Decimal digits of 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2).
  localparam int NDIG  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_W = $clog2(NDIG + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_SKIP  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_DIGIT = 6'b010000,
    S_TERM  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIG_W-1:0]       dig_r, dig_nxt;
  logic [3:0]             len_r, len_nxt;
  sida_pkg::cls_t         cls_r, cls_nxt;
  logic [3:0]             top_dig;

  sida_pkg::chr_t         emit_chr;
  logic                   emit_req, emit_ok;
  logic [1:0]             oq_cnt_r, oq_cnt_nxt;
  logic                   oq_wr_r, oq_rd_r;
  sida_pkg::chr_t         oq_mem [2];
  logic                   oq_pop_ok, oq_space;

  assign top_dig = bcd_r[BCD_W-1 -: 4];

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ?
                          (bcd_r[4*i +: 4] + 4'd3) : bcd_r[4*i +: 4];
    end
  end

  assign oq_pop_ok = out_pop && (oq_cnt_r != 2'd0);
  assign oq_space  = (oq_cnt_r != 2'd2) || oq_pop_ok;
  assign emit_ok   = emit_req && oq_space;

  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    len_nxt   = len_r;
    cls_nxt   = cls_r;
    fq_pop    = 1'b0;
    emit_req  = 1'b0;
    emit_chr  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (fq_stat.valid) begin
          fq_pop    = 1'b1;
          bin_nxt   = fq_mag;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_WIDTH);
          cls_nxt   = fq_stat.cls;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          dig_nxt   = DIG_W'(NDIG);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zeros one digit a cycle, keeping at least one digit.
        if ((top_dig == 4'd0) && (dig_r != DIG_W'(1))) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt = dig_r - DIG_W'(1);
        end else begin
          len_nxt   = 4'(8'(dig_r) + 8'(cls_r.has_sign));
          state_nxt = cls_r.has_sign ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        emit_req           = 1'b1;
        emit_chr.character = cls_r.neg ? sida_pkg::CH_MINUS : sida_pkg::CH_PLUS;
        if (emit_ok) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        emit_req           = 1'b1;
        emit_chr.character = sida_pkg::CH_ZERO + {4'd0, top_dig};
        if ((dig_r == DIG_W'(1)) && !cls_r.term) begin
          emit_chr.last   = 1'b1;
          emit_chr.length = len_r;
        end
        if (emit_ok) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt = dig_r - DIG_W'(1);
          if (dig_r == DIG_W'(1)) begin
            state_nxt = cls_r.term ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        emit_req           = 1'b1;
        emit_chr.character = sida_pkg::CH_NUL;
        emit_chr.last      = 1'b1;
        emit_chr.length    = len_r;
        if (emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (emit_ok && !oq_pop_ok) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (oq_pop_ok && !emit_ok) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oq_cnt_r <= 2'd0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (emit_ok) begin
        oq_wr_r <= !oq_wr_r;
      end
      if (oq_pop_ok) begin
        oq_rd_r <= !oq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
    cnt_r <= cnt_nxt;
    dig_r <= dig_nxt;
    len_r <= len_nxt;
    cls_r <= cls_nxt;
    if (emit_ok) begin
      oq_mem[oq_wr_r] <= emit_chr;
    end
  end

  assign out_empty     = (oq_cnt_r == 2'd0);
  assign out_character = oq_mem[oq_rd_r].character;
  assign out_last      = oq_mem[oq_rd_r].last;
  assign out_length    = oq_mem[oq_rd_r].length;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text, one character per result word.
// Each word is loaded, converted by the bit-serial BCD loop, stripped of leading zeros
// with its length fixed, then emitted one character per result word (up to 12
// for a width of 32); emission stalls while the result queue is full. The back part
// takes a new word only after the last one is fully queued; the front queue holds two.
// Synchronous active-low reset empties both queues and clears show_plus to 0.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_add_terminator,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [7:0]             out_character,
  output logic                   out_last,
  output logic [3:0]             out_length,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_show_plus
);

  sida_pkg::fq_stat_t     fq_stat;
  logic [VALUE_WIDTH-1:0] fq_mag;
  logic                   fq_pop;

  sida_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_value          (in_value),
    .in_add_terminator (in_add_terminator),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_show_plus     (cfg_show_plus),
    .fq_stat           (fq_stat),
    .fq_mag            (fq_mag),
    .fq_pop            (fq_pop)
  );

  sida_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fq_stat       (fq_stat),
    .fq_mag        (fq_mag),
    .fq_pop        (fq_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_character (out_character),
    .out_last      (out_last),
    .out_length    (out_length)
  );

endmodule

// ===== rtl/sida_checker.sv =====
// Port-level checks for signed_int_to_decimal_ascii, attached by the bind below.
// Depends only on the top level's ports.
module sida_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_character,
  input logic       out_last,
  input logic [3:0] out_length
);

  // After reset both queues are empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // Only the closing word of a text carries a length.
  a_length_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> (out_length == 4'd0))
    else $error("length shown on a word that is not last");

  // A terminator is always the closing word.
  a_nul_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_character == 8'h00)) |-> out_last)
    else $error("NUL word without last");

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_character) && $stable(out_last)))
    else $error("result word changed while stalled");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_character (out_character),
  .out_last      (out_last),
  .out_length    (out_length)
);
